// File: rtl/pbfa_pkg.sv
// Shared types and constants for the per-bin frame accumulator.
package pbfa_pkg;

    // Signed Q7.16 sample and sum width.
    localparam int DATA_W = 24;
    // Width of a phase wrapped into [-pi, pi), and of a value in [0, 2pi).
    localparam int PH_W = 19;
    // Configuration data width (widest register, frame_length).
    localparam int CFG_W = 10;
    localparam int CFG_IDX_W = 1;

    // pi and 2*pi in Q7.16.
    localparam int Q_PI = 205887;
    localparam int Q_TWO_PI = 2 * Q_PI;

    // Number of register stages in the modulo 2*pi unit.
    localparam int MOD_LAT = 4;

    // Defaults.
    localparam int MAX_BINS_DEF = 512;
    localparam int FL_RESET = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WRAP_MODE    = 1'b0,
        CFG_FRAME_LENGTH = 1'b1
    } t_cfg_reg;

endpackage

// File: rtl/pbfa_mod2pi.sv
// Pipelined floor modulo 2*pi of a signed value, by reciprocal multiplication.
module pbfa_mod2pi
    import pbfa_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [DATA_W:0]  i_x,
    output logic [PH_W-1:0]         o_r
);

    // The input is lifted by a whole number of periods so that it is never negative.
    localparam int U_W = 26;
    localparam int NWRAP = ((1 << DATA_W) + Q_TWO_PI - 1) / Q_TWO_PI;
    localparam int OFFSET = NWRAP * Q_TWO_PI;
    localparam int SHIFT = 32;
    localparam longint unsigned RECIP_L = (64'd1 << SHIFT) / Q_TWO_PI;
    localparam int R_W = 14;
    localparam logic [R_W-1:0] RECIP = R_W'(RECIP_L);
    localparam int P_W = U_W + R_W;
    localparam int Q_W = P_W - SHIFT;
    localparam int QC_W = Q_W + PH_W;

    logic signed [U_W:0] n_sum;
    logic [U_W-1:0]      r_u1;
    logic [U_W-1:0]      r_u2;
    logic [U_W-1:0]      r_u3;
    logic [P_W-1:0]      r_p;
    logic [QC_W-1:0]     r_qc;
    logic [QC_W-1:0]     n_diff;
    logic [QC_W-1:0]     n_rem;
    logic [PH_W-1:0]     r_r;

    always_comb begin
        n_sum = (U_W+1)'(i_x) + (U_W+1)'(OFFSET);
    end

    // The estimated quotient is exact or one short, so one correction step suffices.
    always_comb begin
        n_diff = QC_W'(r_u3) - r_qc;
        if (n_diff >= QC_W'(Q_TWO_PI)) begin
            n_rem = n_diff - QC_W'(Q_TWO_PI);
        end else begin
            n_rem = n_diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u1 <= n_sum[U_W-1:0];
            r_p  <= P_W'(r_u1) * P_W'(RECIP);
            r_u2 <= r_u1;
            r_qc <= QC_W'(r_p[P_W-1:SHIFT]) * QC_W'(Q_TWO_PI);
            r_u3 <= r_u2;
            r_r  <= PH_W'(n_rem);
        end
    end

    assign o_r = r_r;

endmodule

// File: rtl/per_bin_frame_accumulator.sv
// Per-bin frame accumulator: one running Q7.16 sum per bin, wrapped or saturated.
//
// Usage. Samples enter on the input channel (i_valid / o_stall, payload i_sample),
// one per cycle while o_stall is low, and are taken as consecutive bins of a frame
// of frame_length bins. Each request yields one result on the output channel
// (o_valid / i_stall) carrying the bin's updated sum and a flag on the last bin of
// the frame. Configuration must be written through i_cfg_we / i_cfg_idx /
// i_cfg_data only while the block is idle; the block does not enforce this.
// Register 0 is wrap_mode, register 1 is frame_length; a frame_length write clears
// every sum and restarts at bin 0. Requests pass the input, update and write-back
// stages and the output register. Throughput: one request per cycle while the
// receiver does not stall. The sums live in one memory with a read port and a
// write port; the read-add-write loop closes through forwarding from the write-back
// stages, so the same bin may come back on every cycle. Reset sets wrap_mode to 0
// and frame_length to 64 and clears the sums at once: until the first frame has
// passed, reads of the memory are taken as zero, so no clearing pass is needed.
// When the receiver stalls with a result waiting, the pipeline keeps moving until
// its last stage holds a result, then freezes and raises o_stall.
module per_bin_frame_accumulator
    import pbfa_pkg::*;
#(
    parameter int MAX_BINS = MAX_BINS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [DATA_W-1:0] i_sample,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_sum_value,
    output logic                     o_frame_end,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data
);

    localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int MEM_W = DATA_W + PH_W;
    localparam int LAST_RESET_INT = ((FL_RESET > MAX_BINS) ? MAX_BINS : FL_RESET) - 1;
    localparam logic [IDX_W-1:0] LAST_RESET = IDX_W'(LAST_RESET_INT);
    localparam int LQ = MOD_LAT - 1;

    // Configuration and bin position.
    logic             r_wrap;
    logic [IDX_W-1:0] r_last;
    logic [IDX_W-1:0] r_bin_idx;
    logic             r_first;
    logic [31:0]      n_len;
    logic [IDX_W-1:0] n_last;

    // Handshake.
    logic pipe_en;
    logic in_acc;
    logic at_last;

    // Input stages, aligned with the sample modulo unit.
    logic                     r_p_valid  [MOD_LAT];
    logic                     r_p_first  [MOD_LAT];
    logic                     r_p_fend   [MOD_LAT];
    logic [IDX_W-1:0]         r_p_idx    [MOD_LAT];
    logic signed [DATA_W-1:0] r_p_sample [MOD_LAT];
    logic [PH_W-1:0]          smod;

    // Update stage, facing the memory read data.
    logic                     r_l_valid;
    logic                     r_l_first;
    logic                     r_l_fend;
    logic [IDX_W-1:0]         r_l_idx;
    logic signed [DATA_W-1:0] r_l_sample;
    logic [PH_W-1:0]          r_l_smod;
    logic [MEM_W-1:0]         r_rdata;

    // Write-back stages, aligned with the shadow modulo unit.
    logic                     r_q_valid [MOD_LAT];
    logic                     r_q_fend  [MOD_LAT];
    logic [IDX_W-1:0]         r_q_idx   [MOD_LAT];
    logic signed [DATA_W-1:0] r_q_val   [MOD_LAT];
    logic [PH_W-1:0]          vmod;
    logic signed [PH_W-1:0]   shadow;

    // Entry written at the most recent pipeline step.
    logic                     r_lw_valid;
    logic [IDX_W-1:0]         r_lw_idx;
    logic signed [DATA_W-1:0] r_lw_val;

    // Output register.
    logic                     r_o_valid;
    logic signed [DATA_W-1:0] r_o_sum;
    logic                     r_o_fend;

    // Each entry keeps the plain sum and, beside it, that sum wrapped into
    // [-pi, pi), so that a switch to wrap mode never needs a full modulo
    // inside the update loop.
    logic [MEM_W-1:0] r_mem [MAX_BINS];

    logic                     fwd_hit;
    logic signed [DATA_W-1:0] fwd_val;
    logic signed [DATA_W-1:0] base_plain;
    logic signed [PH_W-1:0]   base_wrap;
    logic signed [PH_W+1:0]   wsum;
    logic signed [PH_W+1:0]   wadj;
    logic signed [DATA_W:0]   psum;
    logic signed [DATA_W-1:0] pres;
    logic signed [DATA_W-1:0] n_val;
    logic signed [DATA_W:0]   mod2_x;

    // The pipeline moves unless its last stage holds a result that cannot
    // enter the output register.
    assign pipe_en = !(r_q_valid[LQ] && r_o_valid && i_stall);
    assign o_stall = !pipe_en;
    assign in_acc  = i_valid && pipe_en;
    assign at_last = (r_bin_idx == r_last);

    // Effective frame length: zero acts as one, and it never exceeds the store.
    always_comb begin
        n_len = 32'(i_cfg_data);
        if (n_len == 32'd0) begin
            n_len = 32'd1;
        end
        if (n_len > 32'(MAX_BINS)) begin
            n_len = 32'(MAX_BINS);
        end
        n_last = IDX_W'(n_len - 32'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap    <= 1'b0;
            r_last    <= LAST_RESET;
            r_bin_idx <= '0;
            r_first   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_WRAP_MODE: begin
                    r_wrap <= i_cfg_data[0];
                end
                CFG_FRAME_LENGTH: begin
                    r_last    <= n_last;
                    r_bin_idx <= '0;
                    r_first   <= 1'b1;
                end
            endcase
        end else if (in_acc) begin
            if (at_last) begin
                r_bin_idx <= '0;
                r_first   <= 1'b0;
            end else begin
                r_bin_idx <= r_bin_idx + IDX_W'(1);
            end
        end
    end

    // Sample reduced modulo 2*pi for the wrap-mode update.
    pbfa_mod2pi u_mod_sample (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_x   ((DATA_W+1)'(i_sample)),
        .o_r   (smod)
    );

    // Valid bits of every stage are reset; payload and flags are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MOD_LAT; k++) begin
                r_p_valid[k] <= 1'b0;
                r_q_valid[k] <= 1'b0;
            end
            r_l_valid  <= 1'b0;
            r_lw_valid <= 1'b0;
        end else if (pipe_en) begin
            r_p_valid[0] <= in_acc;
            r_q_valid[0] <= r_l_valid;
            for (int k = 1; k < MOD_LAT; k++) begin
                r_p_valid[k] <= r_p_valid[k-1];
                r_q_valid[k] <= r_q_valid[k-1];
            end
            r_l_valid  <= r_p_valid[LQ];
            r_lw_valid <= r_q_valid[LQ];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_p_first[0]  <= r_first;
            r_p_fend[0]   <= at_last;
            r_p_idx[0]    <= r_bin_idx;
            r_p_sample[0] <= i_sample;
            for (int k = 1; k < MOD_LAT; k++) begin
                r_p_first[k]  <= r_p_first[k-1];
                r_p_fend[k]   <= r_p_fend[k-1];
                r_p_idx[k]    <= r_p_idx[k-1];
                r_p_sample[k] <= r_p_sample[k-1];
            end
            r_l_first  <= r_p_first[LQ];
            r_l_fend   <= r_p_fend[LQ];
            r_l_idx    <= r_p_idx[LQ];
            r_l_sample <= r_p_sample[LQ];
            r_l_smod   <= smod;
            r_q_fend[0] <= r_l_fend;
            r_q_idx[0]  <= r_l_idx;
            r_q_val[0]  <= n_val;
            for (int k = 1; k < MOD_LAT; k++) begin
                r_q_fend[k] <= r_q_fend[k-1];
                r_q_idx[k]  <= r_q_idx[k-1];
                r_q_val[k]  <= r_q_val[k-1];
            end
            r_lw_idx <= r_q_idx[LQ];
            r_lw_val <= r_q_val[LQ];
        end
    end

    // Sum memory: one read and one write per pipeline step.
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_rdata <= r_mem[r_p_idx[LQ]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en && r_q_valid[LQ]) begin
            r_mem[r_q_idx[LQ]] <= {r_q_val[LQ], shadow};
        end
    end

    // Forwarding: sums still in the write-back stages, or written on the same
    // step as the read, are newer than the read data. The youngest match wins.
    always_comb begin
        fwd_hit = r_lw_valid && (r_lw_idx == r_l_idx);
        fwd_val = r_lw_val;
        for (int k = LQ; k >= 0; k--) begin
            if (r_q_valid[k] && (r_q_idx[k] == r_l_idx)) begin
                fwd_hit = 1'b1;
                fwd_val = r_q_val[k];
            end
        end
    end

    // Update. A bin seen for the first time since a clear starts from zero.
    // In wrap mode every stored or forwarded sum already lies in [-pi, pi).
    always_comb begin
        if (r_l_first) begin
            base_plain = '0;
            base_wrap  = '0;
        end else if (fwd_hit) begin
            base_plain = fwd_val;
            base_wrap  = fwd_val[PH_W-1:0];
        end else begin
            base_plain = r_rdata[MEM_W-1:PH_W];
            base_wrap  = r_rdata[PH_W-1:0];
        end

        wsum = (PH_W+2)'(base_wrap) + $signed({2'b00, r_l_smod});
        if (wsum >= $signed((PH_W+2)'(Q_PI))) begin
            wadj = wsum - $signed((PH_W+2)'(Q_TWO_PI));
        end else begin
            wadj = wsum;
        end

        psum = (DATA_W+1)'(base_plain) + (DATA_W+1)'(r_l_sample);
        if (psum[DATA_W] != psum[DATA_W-1]) begin
            pres = psum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            pres = psum[DATA_W-1:0];
        end

        n_val  = r_wrap ? DATA_W'(wadj) : pres;
        mod2_x = (DATA_W+1)'(n_val) + (DATA_W+1)'(Q_PI);
    end

    // Wrapped copy of each new sum, computed off the update loop.
    pbfa_mod2pi u_mod_shadow (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_x   (mod2_x),
        .o_r   (vmod)
    );

    assign shadow = vmod - PH_W'(Q_PI);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (pipe_en && r_q_valid[LQ]) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en && r_q_valid[LQ]) begin
            r_o_sum  <= r_q_val[LQ];
            r_o_fend <= r_q_fend[LQ];
        end
    end

    assign o_valid     = r_o_valid;
    assign o_sum_value = r_o_sum;
    assign o_frame_end = r_o_fend;

    // The bin position never runs past the last bin of the frame.
    a_bin_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bin_idx <= r_last)
        else $error("bin index beyond frame length");

    // The last bin of a frame sends the position back to bin 0.
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && at_last && !i_cfg_we) |=> (r_bin_idx == '0))
        else $error("bin index did not restart after frame end");

    // The modulo unit always lands in [0, 2*pi) for a sum about to be stored.
    a_shadow_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_valid[LQ] |-> (vmod < PH_W'(Q_TWO_PI)))
        else $error("wrapped copy out of range");

endmodule

// File: test/tb.sv
// Testbench for per_bin_frame_accumulator: directed table, random phases, predicted sums.
`timescale 1ns / 100ps

module tb;
    import pbfa_pkg::*;

    localparam int N_BINS = MAX_BINS_DEF;
    localparam longint SUM_MAX = 64'sd8388607;
    localparam longint SUM_MIN = -64'sd8388608;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT = 200000;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;

    typedef struct {
        logic signed [DATA_W-1:0] sum;
        logic                     frame_end;
    } t_bin_result;

    typedef struct {
        bit                       is_cfg;
        bit                       wrap;
        bit                       set_len;
        logic [CFG_W-1:0]         len;
        logic signed [DATA_W-1:0] sample;
        bit                       typed;
        logic signed [DATA_W-1:0] sum;
        logic                     frame_end;
    } t_stim_row;

    typedef struct {
        bit               wrap;
        bit               set_len;
        logic [CFG_W-1:0] len;
        int               count;
        t_idle            idle;
        bit               squeeze;
    } t_phase;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic signed [DATA_W-1:0] i_sample = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic signed [DATA_W-1:0] o_sum_value;
    logic                     o_frame_end;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_idx = CFG_WRAP_MODE;
    logic [CFG_W-1:0]         i_cfg_data = '0;

    per_bin_frame_accumulator #(
        .MAX_BINS(N_BINS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_sample   (i_sample),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_sum_value(o_sum_value),
        .o_frame_end(o_frame_end),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Our own copy of the block state and configuration.
    logic signed [DATA_W-1:0] model_sums [N_BINS];
    int unsigned              model_bin;
    bit                       model_wrap;
    logic [CFG_W-1:0]         model_len;

    t_bin_result pending_sums [$];
    int          err_cnt = 0;
    int          cycle_cnt = 0;
    int          send_pct = 0;
    int          recv_pct = 0;
    int unsigned hold_req = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    t_stim_row stim_rows [$];
    t_phase    phases [$];

    task automatic clear_model_store();
        for (int i = 0; i < N_BINS; i++) begin
            model_sums[i] = '0;
        end
        model_bin = 0;
    endtask

    // Adds one sample to the sum of the current bin and advances the bin position.
    function automatic t_bin_result accumulate_bin(logic signed [DATA_W-1:0] sample);
        t_bin_result res;
        int unsigned len;
        int unsigned idx;
        longint      s;
        longint      m;
        len = 32'(model_len);
        if (len == 0) begin
            len = 1;
        end
        if (len > N_BINS) begin
            len = N_BINS;
        end
        idx = model_bin;
        if (idx >= len) begin
            idx = 0;
        end
        s = longint'(model_sums[idx]) + longint'(sample);
        if (model_wrap) begin
            // Floor modulo of (s + pi) by 2*pi, shifted back by pi.
            m = (s + Q_PI) % Q_TWO_PI;
            if (m < 0) begin
                m = m + Q_TWO_PI;
            end
            s = m - Q_PI;
        end else if (s > SUM_MAX) begin
            s = SUM_MAX;
        end else if (s < SUM_MIN) begin
            s = SUM_MIN;
        end
        res.sum = s[DATA_W-1:0];
        res.frame_end = (idx + 1 == len);
        model_sums[idx] = res.sum;
        model_bin = (idx + 1 >= len) ? 0 : idx + 1;
        return res;
    endfunction

    function automatic logic signed [DATA_W-1:0] draw_sample();
        logic signed [DATA_W-1:0] v;
        v = DATA_W'($urandom());
        case ($urandom_range(0, 9))
            0, 1, 2, 3: ;
            4, 5: v = DATA_W'($signed($urandom_range(0, 262143)) - 131072);
            6: v = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            7: v = DATA_W'(($urandom_range(0, 1) ? Q_PI : -Q_PI)
                           + $signed($urandom_range(0, 8)) - 4);
            8: v = DATA_W'(($urandom_range(0, 1) ? 24'sh400000 : -24'sh400000)
                           + $signed($urandom_range(0, 65535)));
            default: v = DATA_W'($signed($urandom_range(0, 2)) - 1);
        endcase
        return v;
    endfunction

    function automatic t_stim_row cfg_row(bit wrap, bit set_len, logic [CFG_W-1:0] len);
        t_stim_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.wrap = wrap;
        r.set_len = set_len;
        r.len = len;
        return r;
    endfunction

    function automatic t_stim_row smp_row(logic signed [DATA_W-1:0] sample, bit typed,
                                          logic signed [DATA_W-1:0] sum, logic frame_end);
        t_stim_row r;
        r = '{default: '0};
        r.sample = sample;
        r.typed = typed;
        r.sum = sum;
        r.frame_end = frame_end;
        return r;
    endfunction

    task automatic set_idle(t_idle mode);
        send_pct = (mode == IDLE_SEND) ? 61 : (mode == IDLE_BOTH) ? 27 : 0;
        recv_pct = (mode == IDLE_RECV) ? 61 : (mode == IDLE_BOTH) ? 27 : 0;
    endtask

    // Registers are only written once every expected result has come back.
    task automatic write_regs(bit wrap, bit set_len, logic [CFG_W-1:0] len);
        i_valid <= 1'b0;
        while (pending_sums.size() != 0) begin
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_WRAP_MODE;
        i_cfg_data <= CFG_W'(wrap);
        @(posedge i_clk);
        model_wrap = wrap;
        if (set_len) begin
            i_cfg_idx <= CFG_FRAME_LENGTH;
            i_cfg_data <= len;
            @(posedge i_clk);
            model_len = len;
            clear_model_store();
        end
        i_cfg_we <= 1'b0;
    endtask

    // Offers one request, with random gaps before it, and returns once it is accepted.
    task automatic send_request(logic signed [DATA_W-1:0] sample, output t_bin_result res);
        while ($urandom_range(0, 99) < send_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample <= sample;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        res = accumulate_bin(sample);
    endtask

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_pct);
        end
    end

    // Every accepted result is matched against the oldest expected sum.
    always @(posedge i_clk) begin
        t_bin_result exp_res;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_sums.size() == 0) begin
                $display("%0t: unexpected result sum_value %0d frame_end %0b",
                         $time, o_sum_value, o_frame_end);
                err_cnt++;
            end else begin
                exp_res = pending_sums.pop_front();
                if (o_sum_value !== exp_res.sum) begin
                    $display("%0t: sum_value expected %0d actual %0d",
                             $time, exp_res.sum, o_sum_value);
                    err_cnt++;
                end
                if (o_frame_end !== exp_res.frame_end) begin
                    $display("%0t: frame_end expected %0b actual %0b",
                             $time, exp_res.frame_end, o_frame_end);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        t_bin_result res;

        // Length of one: every request is the last bin, and both saturation limits.
        stim_rows.push_back(cfg_row(1'b0, 1'b1, 10'd1));
        stim_rows.push_back(smp_row(24'sh7FFFFF, 1'b1, 24'sh7FFFFF, 1'b1));
        stim_rows.push_back(smp_row(24'sd1, 1'b1, 24'sh7FFFFF, 1'b1));
        stim_rows.push_back(smp_row(24'sh800000, 1'b1, -24'sd1, 1'b1));
        stim_rows.push_back(smp_row(24'sh800000, 1'b1, 24'sh800000, 1'b1));
        stim_rows.push_back(smp_row(-24'sd1, 1'b1, 24'sh800000, 1'b1));
        // A zero length behaves as one.
        stim_rows.push_back(cfg_row(1'b0, 1'b1, 10'd0));
        stim_rows.push_back(smp_row(24'sd5, 1'b1, 24'sd5, 1'b1));
        stim_rows.push_back(smp_row(24'sd7, 1'b1, 24'sd12, 1'b1));
        // Saturated sums left in place, then wrap mode turned on without a clear.
        stim_rows.push_back(cfg_row(1'b0, 1'b1, 10'd2));
        stim_rows.push_back(smp_row(24'sh7FFFFF, 1'b1, 24'sh7FFFFF, 1'b0));
        stim_rows.push_back(smp_row(24'sh800000, 1'b1, 24'sh800000, 1'b1));
        stim_rows.push_back(cfg_row(1'b1, 1'b0, 10'd0));
        stim_rows.push_back(smp_row(24'sd0, 1'b0, '0, 1'b0));
        stim_rows.push_back(smp_row(24'sd0, 1'b0, '0, 1'b0));
        // Wrap boundaries: pi folds to minus pi, just below minus pi folds up.
        stim_rows.push_back(cfg_row(1'b1, 1'b1, 10'd1));
        stim_rows.push_back(smp_row(DATA_W'(Q_PI), 1'b1, DATA_W'(-Q_PI), 1'b1));
        stim_rows.push_back(smp_row(-24'sd1, 1'b1, DATA_W'(Q_PI - 1), 1'b1));
        stim_rows.push_back(smp_row(24'sd1, 1'b1, DATA_W'(-Q_PI), 1'b1));
        stim_rows.push_back(smp_row(24'sh7FFFFF, 1'b0, '0, 1'b0));
        stim_rows.push_back(smp_row(24'sh800000, 1'b0, '0, 1'b0));
        // Largest length field, limited to the store size.
        stim_rows.push_back(cfg_row(1'b0, 1'b1, 10'd1023));
        stim_rows.push_back(smp_row(24'sd100, 1'b0, '0, 1'b0));
        stim_rows.push_back(smp_row(-24'sd100, 1'b0, '0, 1'b0));
        stim_rows.push_back(smp_row(24'sh123456, 1'b0, '0, 1'b0));
        // A short frame and its wrap back to bin zero.
        stim_rows.push_back(cfg_row(1'b0, 1'b1, 10'd3));
        stim_rows.push_back(smp_row(24'sd1, 1'b1, 24'sd1, 1'b0));
        stim_rows.push_back(smp_row(24'sd2, 1'b1, 24'sd2, 1'b0));
        stim_rows.push_back(smp_row(24'sd3, 1'b1, 24'sd3, 1'b1));
        stim_rows.push_back(smp_row(24'sd4, 1'b1, 24'sd5, 1'b0));

        phases.push_back('{1'b0, 1'b1, 10'd5, 150, IDLE_NONE, 1'b0});
        phases.push_back('{1'b1, 1'b1, 10'd17, 150, IDLE_SEND, 1'b0});
        phases.push_back('{1'b0, 1'b1, 10'd0, 60, IDLE_RECV, 1'b0});
        phases.push_back('{1'b1, 1'b1, 10'd1023, 530, IDLE_BOTH, 1'b0});
        phases.push_back('{1'b0, 1'b1, 10'd2, 100, IDLE_NONE, 1'b1});
        phases.push_back('{1'b1, 1'b0, 10'd0, 80, IDLE_RECV, 1'b0});
        phases.push_back('{1'b0, 1'b1, 10'd64, 150, IDLE_SEND, 1'b0});
        phases.push_back('{1'b0, 1'b1, 10'd300, 130, IDLE_BOTH, 1'b0});

        model_wrap = 1'b0;
        model_len = CFG_W'(FL_RESET);
        clear_model_store();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idle(IDLE_NONE);
        foreach (stim_rows[i]) begin
            if (stim_rows[i].is_cfg) begin
                write_regs(stim_rows[i].wrap, stim_rows[i].set_len, stim_rows[i].len);
            end else begin
                send_request(stim_rows[i].sample, res);
                if (stim_rows[i].typed) begin
                    res.sum = stim_rows[i].sum;
                    res.frame_end = stim_rows[i].frame_end;
                end
                pending_sums.push_back(res);
            end
        end

        foreach (phases[p]) begin
            write_regs(phases[p].wrap, phases[p].set_len, phases[p].len);
            set_idle(phases[p].idle);
            // The receiver holds off while requests keep coming, so the block backs up.
            if (phases[p].squeeze) begin
                hold_req++;
            end
            for (int n = 0; n < phases[p].count; n++) begin
                send_request(draw_sample(), res);
                pending_sums.push_back(res);
            end
        end

        i_valid <= 1'b0;
        while (pending_sums.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// File: per_bin_frame_accumulator.f
rtl/pbfa_pkg.sv
rtl/pbfa_mod2pi.sv
rtl/per_bin_frame_accumulator.sv
test/tb.sv
